// ----- design/cma_pkg.sv -----
// Package for the cluster mean accumulator.
// Holds field widths, operation and status codes, and the divider handshake struct.
// No dependencies; every other file of the block uses it.
`default_nettype none

package cma_pkg;

  // Field and state widths.
  localparam int COORD_BITS = 12;
  localparam int COUNT_BITS = 16;
  localparam int DIST_BITS  = 24;
  localparam int SUM_BITS   = COUNT_BITS + COORD_BITS;
  localparam int STEP_BITS  = $clog2(COORD_BITS + 1);

  // Largest number of points the cluster holds.
  localparam logic [COUNT_BITS-1:0] MAX_POINTS = 16'd65535;

  // Operation codes; codes above OP_CLEAR are ignored.
  localparam logic [2:0] OP_ADD          = 3'd0;
  localparam logic [2:0] OP_ADD_DIST     = 3'd1;
  localparam logic [2:0] OP_SET_CENTROID = 3'd2;
  localparam logic [2:0] OP_RECOMPUTE    = 3'd3;
  localparam logic [2:0] OP_CLEAR        = 3'd4;

  // Status codes of a result beat.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Status returned by the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- design/cluster_mean_accumulator_top.sv -----
// Cluster mean accumulator: one cluster of a k-means style clusterer.
// Sequencer, cluster state and result register; uses cma_pkg and cma_divider.
// Depends on cma_pkg and cma_divider.
//
// Each input beat carries one operation and gives exactly one result beat that shows the
// cluster state after it. Add, set-centroid, clear and unused codes go from the idle state
// to the response state and back. A recompute of a non-empty cluster first passes the two
// divide states: the single shared divider runs 12 steps, first for x and then for y.
// in_ready is high whenever the sequencer is idle, also while an earlier result beat
// still waits on out_ready; a new result then waits until the output register frees.
`default_nettype none

module cluster_mean_accumulator_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [2:0]                     operation,
  input  wire logic [cma_pkg::COORD_BITS-1:0] x_coord,
  input  wire logic [cma_pkg::COORD_BITS-1:0] y_coord,
  input  wire logic [cma_pkg::DIST_BITS-1:0]  distance,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [1:0]                          status,
  output logic [cma_pkg::COORD_BITS-1:0]      centroid_x,
  output logic [cma_pkg::COORD_BITS-1:0]      centroid_y,
  output logic [cma_pkg::COUNT_BITS-1:0]      point_count,
  output logic                                farthest_valid,
  output logic [cma_pkg::COUNT_BITS-1:0]      farthest_index,
  output logic [cma_pkg::COORD_BITS-1:0]      farthest_x,
  output logic [cma_pkg::COORD_BITS-1:0]      farthest_y,
  output logic [cma_pkg::DIST_BITS-1:0]       farthest_distance
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_DIV_X = 4'b0010,
    S_DIV_Y = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state;

  // Cluster state.
  logic [cma_pkg::SUM_BITS-1:0]   sum_x;
  logic [cma_pkg::SUM_BITS-1:0]   sum_y;
  logic [cma_pkg::COUNT_BITS-1:0] count;
  logic [cma_pkg::COORD_BITS-1:0] centre_x;
  logic [cma_pkg::COORD_BITS-1:0] centre_y;
  logic                           far_valid;
  logic [cma_pkg::DIST_BITS-1:0]  far_dist;
  logic [cma_pkg::COUNT_BITS-1:0] far_index;
  logic [cma_pkg::COORD_BITS-1:0] far_x;
  logic [cma_pkg::COORD_BITS-1:0] far_y;
  logic [cma_pkg::COORD_BITS-1:0] quot_x;
  logic [1:0]                     status_reg;

  logic                           accept;
  logic                           is_add;
  logic                           full;
  logic                           new_far;
  logic                           out_free;

  // Divider hookup.
  logic                           div_start;
  logic [cma_pkg::SUM_BITS-1:0]   div_dividend;
  cma_pkg::div_status_t           div_stat;
  logic [cma_pkg::COORD_BITS-1:0] div_quot;

  cma_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // Decode of the incoming beat.
  always_comb begin
    in_ready = (state == S_IDLE);
    accept   = in_valid && in_ready;
    is_add   = (operation == cma_pkg::OP_ADD) || (operation == cma_pkg::OP_ADD_DIST);
    full     = (count >= cma_pkg::MAX_POINTS);
    new_far  = (operation == cma_pkg::OP_ADD_DIST) && (!far_valid || (distance > far_dist));
    out_free = !out_valid || out_ready;
  end

  // Divider start: x on a recompute of a non-empty cluster, y once x is done.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_x;
    if (accept && (operation == cma_pkg::OP_RECOMPUTE) && (count != '0)) begin
      div_start = 1'b1;
    end else if ((state == S_DIV_X) && div_stat.done) begin
      div_start    = 1'b1;
      div_dividend = sum_y;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= div_start ? S_DIV_X : S_RESP;
          end
        end
        S_DIV_X: begin
          if (div_stat.done) begin
            state <= S_DIV_Y;
          end
        end
        S_DIV_Y: begin
          if (div_stat.done) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Cluster state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x      <= '0;
      sum_y      <= '0;
      count      <= '0;
      centre_x   <= '0;
      centre_y   <= '0;
      far_valid  <= 1'b0;
      far_dist   <= '0;
      far_index  <= '0;
      far_x      <= '0;
      far_y      <= '0;
      status_reg <= cma_pkg::ST_OK;
    end else if (accept) begin
      status_reg <= cma_pkg::ST_OK;
      if (is_add) begin
        if (full) begin
          status_reg <= cma_pkg::ST_FULL;
        end else begin
          sum_x <= sum_x + cma_pkg::SUM_BITS'(x_coord);
          sum_y <= sum_y + cma_pkg::SUM_BITS'(y_coord);
          count <= count + 1'b1;
          if (new_far) begin
            far_valid <= 1'b1;
            far_dist  <= distance;
            far_index <= count;
            far_x     <= x_coord;
            far_y     <= y_coord;
          end
        end
      end else if (operation == cma_pkg::OP_SET_CENTROID) begin
        centre_x <= x_coord;
        centre_y <= y_coord;
      end else if (operation == cma_pkg::OP_RECOMPUTE) begin
        if (count == '0) begin
          status_reg <= cma_pkg::ST_EMPTY;
        end
      end else if (operation == cma_pkg::OP_CLEAR) begin
        sum_x     <= '0;
        sum_y     <= '0;
        count     <= '0;
        far_valid <= 1'b0;
        far_dist  <= '0;
        far_index <= '0;
        far_x     <= '0;
        far_y     <= '0;
      end
    end else if ((state == S_DIV_X) && div_stat.done) begin
      quot_x <= div_quot;
    end else if ((state == S_DIV_Y) && div_stat.done) begin
      centre_x <= quot_x;
      centre_y <= div_quot;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_RESP) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: result beat payload.
  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      status            <= status_reg;
      centroid_x        <= centre_x;
      centroid_y        <= centre_y;
      point_count       <= count;
      farthest_valid    <= far_valid;
      farthest_index    <= far_index;
      farthest_x        <= far_x;
      farthest_y        <= far_y;
      farthest_distance <= far_dist;
    end
  end

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> ((state == S_DIV_X) || (state == S_DIV_Y)))
    else $error("divider finished outside a divide state");

  // An accepted add below the limit grows the count by one.
  a_add_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && is_add && !full) |=> (count == $past(count) + 1'b1))
    else $error("accepted point not counted");

  // A pending result is moved into a free output register.
  a_resp_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_RESP) && out_free) |=> (out_valid && (state == S_IDLE)))
    else $error("result beat not loaded");

  // The divider never gets a new start while it is stepping.
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !div_start)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

// ----- design/cma_divider.sv -----
// Shared restoring divider of the cluster mean accumulator, one quotient bit per cycle.
// Divides a coordinate sum by the point count; the quotient is known to fit a coordinate.
// Depends on cma_pkg.
`default_nettype none

module cma_divider (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [cma_pkg::SUM_BITS-1:0]   dividend,
  input  wire logic [cma_pkg::COUNT_BITS-1:0] divisor,
  output cma_pkg::div_status_t                stat,
  output logic [cma_pkg::COORD_BITS-1:0]      quotient
);

  logic [cma_pkg::COUNT_BITS-1:0] rem;
  logic [cma_pkg::COORD_BITS-1:0] dq;
  logic [cma_pkg::COUNT_BITS-1:0] div_reg;
  logic [cma_pkg::STEP_BITS-1:0]  cnt;
  logic                           busy;
  logic                           done;
  logic [cma_pkg::COUNT_BITS:0]   trial;
  logic [cma_pkg::COUNT_BITS:0]   diff;
  logic                           fits;

  // One trial subtraction: bring down the next dividend bit and compare.
  always_comb begin
    trial = {rem, dq[cma_pkg::COORD_BITS-1]};
    diff  = trial - {1'b0, div_reg};
    fits  = (trial >= {1'b0, div_reg});
  end

  // Step control. The sum is below count times 2^COORD_BITS, so its upper part
  // is already a valid partial remainder and only the low bits need steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= cma_pkg::STEP_BITS'(cma_pkg::COORD_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == cma_pkg::STEP_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= dividend[cma_pkg::SUM_BITS-1:cma_pkg::COORD_BITS];
      dq      <= dividend[cma_pkg::COORD_BITS-1:0];
      div_reg <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[cma_pkg::COUNT_BITS-1:0] : trial[cma_pkg::COUNT_BITS-1:0];
      dq  <= {dq[cma_pkg::COORD_BITS-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = dq;

endmodule

`default_nettype wire

// ----- tb/cma_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the cluster mean accumulator: tracks the cluster state beat by beat.
// Watches both channels, queues the predicted result of every input beat and compares.
// Depends on cma_pkg; instantiated by tb_cluster_mean_accumulator_top.

module cma_result_checker
  import cma_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [2:0]            operation,
  input  wire logic [COORD_BITS-1:0] x_coord,
  input  wire logic [COORD_BITS-1:0] y_coord,
  input  wire logic [DIST_BITS-1:0]  distance,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [1:0]            status,
  input  wire logic [COORD_BITS-1:0] centroid_x,
  input  wire logic [COORD_BITS-1:0] centroid_y,
  input  wire logic [COUNT_BITS-1:0] point_count,
  input  wire logic                  farthest_valid,
  input  wire logic [COUNT_BITS-1:0] farthest_index,
  input  wire logic [COORD_BITS-1:0] farthest_x,
  input  wire logic [COORD_BITS-1:0] farthest_y,
  input  wire logic [DIST_BITS-1:0]  farthest_distance,
  output int                         fail_count,
  output int                         pending
);

  // Cluster state as seen on one result beat.
  typedef struct packed {
    logic [1:0]            status;
    logic [COORD_BITS-1:0] cent_x;
    logic [COORD_BITS-1:0] cent_y;
    logic [COUNT_BITS-1:0] count;
    logic                  far_valid;
    logic [COUNT_BITS-1:0] far_index;
    logic [COORD_BITS-1:0] far_x;
    logic [COORD_BITS-1:0] far_y;
    logic [DIST_BITS-1:0]  far_dist;
  } cluster_result_t;

  // Tracked copy of the cluster.
  logic [SUM_BITS-1:0]   acc_x, acc_y;
  logic [COUNT_BITS-1:0] n_points;
  logic [COORD_BITS-1:0] mean_x, mean_y;
  logic                  far_seen;
  logic [DIST_BITS-1:0]  far_dist_q;
  logic [COUNT_BITS-1:0] far_index_q;
  logic [COORD_BITS-1:0] far_x_q, far_y_q;

  cluster_result_t expected_results[$];
  cluster_result_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Drop the farthest point record.
  function automatic void forget_far_point();
    far_seen    = 1'b0;
    far_dist_q  = '0;
    far_index_q = '0;
    far_x_q     = '0;
    far_y_q     = '0;
  endfunction

  // Apply one operation to the tracked cluster and return the state after it.
  function automatic cluster_result_t apply_operation(input logic [2:0] op,
                                                      input logic [COORD_BITS-1:0] px,
                                                      input logic [COORD_BITS-1:0] py,
                                                      input logic [DIST_BITS-1:0] d);
    cluster_result_t r;
    logic [1:0]          st;
    logic [SUM_BITS-1:0] qx, qy;
    st = ST_OK;
    case (op)
      OP_ADD, OP_ADD_DIST: begin
        if (n_points >= MAX_POINTS) begin
          st = ST_FULL;
        end else begin
          // The first point with a distance is always taken; later ones only when farther.
          if (op == OP_ADD_DIST && (!far_seen || d > far_dist_q)) begin
            far_seen    = 1'b1;
            far_dist_q  = d;
            far_index_q = n_points;
            far_x_q     = px;
            far_y_q     = py;
          end
          acc_x    = acc_x + SUM_BITS'(px);
          acc_y    = acc_y + SUM_BITS'(py);
          n_points = n_points + 1'b1;
        end
      end
      OP_SET_CENTROID: begin
        mean_x = px;
        mean_y = py;
      end
      OP_RECOMPUTE: begin
        if (n_points == '0) begin
          st = ST_EMPTY;
        end else begin
          qx     = acc_x / SUM_BITS'(n_points);
          qy     = acc_y / SUM_BITS'(n_points);
          mean_x = qx[COORD_BITS-1:0];
          mean_y = qy[COORD_BITS-1:0];
        end
      end
      OP_CLEAR: begin
        // The centroid survives a clear.
        acc_x    = '0;
        acc_y    = '0;
        n_points = '0;
        forget_far_point();
      end
      default: ;
    endcase
    r.status    = st;
    r.cent_x    = mean_x;
    r.cent_y    = mean_y;
    r.count     = n_points;
    r.far_valid = far_seen;
    r.far_index = far_index_q;
    r.far_x     = far_x_q;
    r.far_y     = far_y_q;
    r.far_dist  = far_dist_q;
    return r;
  endfunction

  // One line per mismatch, and the count.
  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, exp_val));
    end
  endtask

  // Output beats are matched before the input beat of the same edge is queued.
  always @(posedge clk) begin
    if (rst) begin
      acc_x    = '0;
      acc_y    = '0;
      n_points = '0;
      mean_x   = '0;
      mean_y   = '0;
      forget_far_point();
      expected_results.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no input beat waiting for it");
        end else begin
          want = expected_results.pop_front();
          check_field("status", status, want.status);
          check_field("centroid_x", centroid_x, want.cent_x);
          check_field("centroid_y", centroid_y, want.cent_y);
          check_field("point_count", point_count, want.count);
          check_field("farthest_valid", farthest_valid, want.far_valid);
          check_field("farthest_index", farthest_index, want.far_index);
          check_field("farthest_x", farthest_x, want.far_x);
          check_field("farthest_y", farthest_y, want.far_y);
          check_field("farthest_distance", farthest_distance, want.far_dist);
        end
      end
      if (in_valid && in_ready) begin
        expected_results.insert(expected_results.size(),
                                apply_operation(operation, x_coord, y_coord, distance));
      end
      pending <= expected_results.size();
    end
  end

endmodule

// ----- tb/tb_cluster_mean_accumulator_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the cluster mean accumulator: clock, reset, stimulus and verdict.
// Depends on cma_pkg, cluster_mean_accumulator_top and cma_result_checker.

module tb_cluster_mean_accumulator_top;
  import cma_pkg::*;

  localparam int          IDLE_LIMIT     = 5000;
  localparam int          RX_HOLD_CYCLES = 300;
  localparam int          DRAIN_CYCLES   = 64;
  localparam int          RANDOM_ITEMS   = 1700;
  localparam logic [2:0]  OP_UNUSED_LO   = OP_CLEAR + 3'd1;
  localparam logic [2:0]  OP_UNUSED_HI   = 3'b111;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic [DIST_BITS-1:0]  DIST_MAX  = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [2:0]            operation = OP_ADD;
  logic [COORD_BITS-1:0] x_coord = '0;
  logic [COORD_BITS-1:0] y_coord = '0;
  logic [DIST_BITS-1:0]  distance = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [1:0]            status;
  logic [COORD_BITS-1:0] centroid_x, centroid_y;
  logic [COUNT_BITS-1:0] point_count;
  logic                  farthest_valid;
  logic [COUNT_BITS-1:0] farthest_index;
  logic [COORD_BITS-1:0] farthest_x, farthest_y;
  logic [DIST_BITS-1:0]  farthest_distance;

  int   fail_count;
  int   pending;
  int   items_sent = 0;
  logic tx_steady = 1'b0;
  logic rx_steady = 1'b0;
  logic rx_hold = 1'b0;

  always #5 clk = ~clk;

  cluster_mean_accumulator_top DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .x_coord           (x_coord),
    .y_coord           (y_coord),
    .distance          (distance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .centroid_x        (centroid_x),
    .centroid_y        (centroid_y),
    .point_count       (point_count),
    .farthest_valid    (farthest_valid),
    .farthest_index    (farthest_index),
    .farthest_x        (farthest_x),
    .farthest_y        (farthest_y),
    .farthest_distance (farthest_distance)
  );

  cma_result_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .operation         (operation),
    .x_coord           (x_coord),
    .y_coord           (y_coord),
    .distance          (distance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .centroid_x        (centroid_x),
    .centroid_y        (centroid_y),
    .point_count       (point_count),
    .farthest_valid    (farthest_valid),
    .farthest_index    (farthest_index),
    .farthest_x        (farthest_x),
    .farthest_y        (farthest_y),
    .farthest_distance (farthest_distance),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // Idle length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return COORD_MAX;
    return COORD_BITS'($urandom);
  endfunction

  // Small distances make ties with the recorded farthest point common.
  function automatic logic [DIST_BITS-1:0] pick_distance();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return DIST_BITS'($urandom_range(0, 3));
    if (r == 3) return DIST_MAX;
    return DIST_BITS'($urandom);
  endfunction

  // Offer one input beat, hold it until accepted, then idle for a picked gap (none when steady).
  task automatic send_beat(input logic [2:0] op, input logic [COORD_BITS-1:0] px,
                           input logic [COORD_BITS-1:0] py, input logic [DIST_BITS-1:0] d);
    int gap;
    in_valid  <= 1'b1;
    operation <= op;
    x_coord   <= px;
    y_coord   <= py;
    distance  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering beats until every result beat has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_point();
    send_beat($urandom_range(0, 1) ? OP_ADD_DIST : OP_ADD, pick_coord(), pick_coord(),
              pick_distance());
  endtask

  // Receiver: random ready stretches, steady stretches, and a long hold-off on request.
  initial begin : receiver
    int len;
    @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 9) < 7);
        len = pick_gap() + 1;
        repeat (len) @(posedge clk);
      end
    end
  end

  // Watchdog: too many cycles in a row without a beat on either channel.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int round;
    int kind;
    int n;
    int target;
    logic saved_steady;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty recompute, unused codes, centroid extremes, farthest-point rules.
    send_beat(OP_RECOMPUTE, '0, '0, '0);
    send_beat(OP_UNUSED_LO, COORD_MAX, '0, DIST_MAX);
    send_beat(OP_UNUSED_LO + 3'd1, '0, COORD_MAX, '0);
    send_beat(OP_UNUSED_HI, COORD_MAX, COORD_MAX, DIST_MAX);
    send_beat(OP_SET_CENTROID, COORD_MAX, COORD_MAX, '0);
    send_beat(OP_RECOMPUTE, '0, '0, '0);
    send_beat(OP_SET_CENTROID, '0, '0, DIST_MAX);
    send_beat(OP_ADD_DIST, '0, '0, '0);
    send_beat(OP_ADD_DIST, COORD_MAX, COORD_MAX, '0);
    send_beat(OP_ADD_DIST, 12'd100, 12'd200, 24'd1);
    send_beat(OP_ADD, COORD_MAX, COORD_MAX, DIST_MAX);
    send_beat(OP_ADD_DIST, 12'd7, 12'd9, DIST_MAX);
    send_beat(OP_ADD_DIST, 12'd1, 12'd1, DIST_MAX);
    send_beat(OP_ADD_DIST, 12'd2, 12'd2, 24'd5);
    send_beat(OP_RECOMPUTE, '0, '0, '0);
    send_beat(OP_CLEAR, COORD_MAX, COORD_MAX, DIST_MAX);
    send_beat(OP_RECOMPUTE, '0, '0, '0);
    send_beat(OP_ADD, COORD_MAX, '0, '0);
    send_beat(OP_ADD, '0, COORD_MAX, '0);
    send_beat(OP_RECOMPUTE, '0, '0, '0);
    send_beat(OP_CLEAR, '0, '0, '0);
    drain_results();

    // Random rounds: mostly add runs closed by a recompute, some noise and broken runs.
    target = items_sent + RANDOM_ITEMS;
    round  = 0;
    while (items_sent < target) begin
      round++;
      tx_steady = ($urandom_range(0, 9) == 0);
      rx_steady = ($urandom_range(0, 9) == 0);

      // Long receiver hold-off while the sender keeps offering back to back.
      if (round == 20 || round == 70) begin
        rx_hold = 1'b1;
        saved_steady = tx_steady;
        tx_steady = 1'b1;
        repeat (16) send_point();
        tx_steady = saved_steady;
      end

      if (round % 25 == 0) drain_results();

      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 2) == 0) send_beat(OP_CLEAR, pick_coord(), pick_coord(),
                                                 pick_distance());
        if ($urandom_range(0, 3) == 0) send_beat(OP_SET_CENTROID, pick_coord(),
                                                 pick_coord(), pick_distance());
        n = $urandom_range(1, 24);
        repeat (n) send_point();
        send_beat(OP_RECOMPUTE, pick_coord(), pick_coord(), pick_distance());
      end else if (kind < 9) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_beat(3'($urandom_range(0, 7)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                    DIST_BITS'($urandom));
        end
      end else begin
        // Broken run: points cleared before their recompute, so the recompute finds an empty cluster.
        n = $urandom_range(0, 4);
        repeat (n) send_point();
        send_beat(OP_CLEAR, pick_coord(), pick_coord(), pick_distance());
        send_beat(OP_RECOMPUTE, pick_coord(), pick_coord(), pick_distance());
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/cma_pkg.sv
design/cma_divider.sv
design/cluster_mean_accumulator_top.sv
tb/cma_result_checker.sv
tb/tb_cluster_mean_accumulator_top.sv
